@@ rtl/wls_pkg.sv @@
// ----------------------------------------------------------------------------
// Weighted lottery selector package
// Shared widths, defaults, register codes and the data words handed along
// the cell chains.
// ----------------------------------------------------------------------------
package wls_pkg;

	localparam int WEIGHT_W   = 8;
	localparam int HW_ENTRIES = 12;
	localparam int LO_ENTRIES = 8;
	localparam int RAND_W     = 16;
	localparam int TOTAL_W    = 12;
	localparam int SEL_W      = 4;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int HI_W       = 32;
	localparam int MASK_W     = 12;
	localparam int GROUP      = 4;
	localparam int GRP_W      = WEIGHT_W + 2;

	localparam int NUM_ENTRIES_DEF    = 12;
	localparam int TEXT_ENTRY_DEF     = 8;
	localparam int FALLBACK_ENTRY_DEF = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_LO  = 3'd0,
		REG_ACTIVE_HI  = 3'd1,
		REG_MEETING_LO = 3'd2,
		REG_MEETING_HI = 3'd3,
		REG_ENABLE     = 3'd4,
		REG_PROFILE    = 3'd5,
		REG_TEXT       = 3'd6
	} cfg_reg_t;

	// Word handed between modulo cells.
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [TOTAL_W-1:0] rem;
		logic [RAND_W-1:0]  dividend;
	} mod_data_t;

	// Word handed between walk cells; the selected index travels beside it.
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [TOTAL_W-1:0] roll;
		logic               found;
	} walk_data_t;

endpackage

@@ rtl/wls_if.sv @@
// ----------------------------------------------------------------------------
// Weighted lottery selector channels
// Valid/ready channels for the random draw and for the pick result.
// ----------------------------------------------------------------------------
interface wls_in_if;
	logic                      valid;
	logic                      ready;
	logic [wls_pkg::RAND_W-1:0] random_value;

	modport source (output valid, output random_value, input ready);
	modport sink (input valid, input random_value, output ready);
endinterface

interface wls_out_if;
	logic                        valid;
	logic                        ready;
	logic [wls_pkg::SEL_W-1:0]   selected_entry;
	logic                        fallback_used;
	logic [wls_pkg::TOTAL_W-1:0] total_weight;

	modport source (output valid, output selected_entry, output fallback_used,
		output total_weight, input ready);
	modport sink (input valid, input selected_entry, input fallback_used,
		input total_weight, output ready);
endinterface

@@ rtl/wls_mod_cell.sv @@
// ----------------------------------------------------------------------------
// Modulo cell
// One restoring step of the draw modulo total: brings in one dividend bit.
// ----------------------------------------------------------------------------
module wls_mod_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_i,
	input  wls_pkg::mod_data_t d_i,
	output logic              valid_o,
	output wls_pkg::mod_data_t d_o
);

	logic [wls_pkg::TOTAL_W:0]   shifted;
	logic [wls_pkg::TOTAL_W:0]   diff;
	logic                        ge;
	wls_pkg::mod_data_t          d_n;
	logic                        valid_s1;
	wls_pkg::mod_data_t          d_s1;

	always_comb begin
		shifted    = {d_i.rem, d_i.dividend[wls_pkg::RAND_W-1]};
		diff       = shifted - {1'b0, d_i.total};
		ge         = (shifted >= {1'b0, d_i.total});
		d_n.total  = d_i.total;
		d_n.rem    = ge ? diff[wls_pkg::TOTAL_W-1:0] : shifted[wls_pkg::TOTAL_W-1:0];
		d_n.dividend = {d_i.dividend[wls_pkg::RAND_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d_n;
		end
	end

	assign valid_o = valid_s1;
	assign d_o     = d_s1;

endmodule

@@ rtl/wls_walk_cell.sv @@
// ----------------------------------------------------------------------------
// Walk cell
// Tests the roll against one entry's weight and either claims the pick or
// takes the weight off the roll.
// ----------------------------------------------------------------------------
module wls_walk_cell #(
	parameter int IDX_W = 4,
	parameter int INDEX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [wls_pkg::WEIGHT_W-1:0]  weight,
	input  logic                          valid_i,
	input  wls_pkg::walk_data_t           d_i,
	input  logic [IDX_W-1:0]              sel_i,
	output logic                          valid_o,
	output wls_pkg::walk_data_t           d_o,
	output logic [IDX_W-1:0]              sel_o
);

	logic [wls_pkg::TOTAL_W-1:0] w_ext;
	logic                        hit;
	wls_pkg::walk_data_t         d_n;
	logic [IDX_W-1:0]            sel_n;
	logic                        valid_s1;
	wls_pkg::walk_data_t         d_s1;
	logic [IDX_W-1:0]            sel_s1;

	always_comb begin
		w_ext   = wls_pkg::TOTAL_W'(weight);
		hit     = !d_i.found && (d_i.roll < w_ext);
		d_n     = d_i;
		sel_n   = sel_i;
		if (hit) begin
			d_n.found = 1'b1;
			sel_n     = IDX_W'(INDEX);
		end else if (!d_i.found) begin
			d_n.roll = d_i.roll - w_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= d_n;
			sel_s1 <= sel_n;
		end
	end

	assign valid_o = valid_s1;
	assign d_o     = d_s1;
	assign sel_o   = sel_s1;

endmodule

@@ rtl/weighted_lottery_selector_unit.sv @@
// ----------------------------------------------------------------------------
// Weighted lottery selector: roulette-wheel pick among weighted entries.
// Takes one word per cycle while the skid register is empty.
// Path: group sums, total, one modulo cell per draw bit, one walk cell per entry.
// Reset (arst_n low) empties the pipeline, clears weights, enables all entries.
// ----------------------------------------------------------------------------
module weighted_lottery_selector_unit #(
	parameter int NUM_ENTRIES    = wls_pkg::NUM_ENTRIES_DEF,
	parameter int TEXT_ENTRY     = wls_pkg::TEXT_ENTRY_DEF,
	parameter int FALLBACK_ENTRY = wls_pkg::FALLBACK_ENTRY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	wls_in_if.sink                          pick_in,
	wls_out_if.source                       pick_out,
	input  logic                            cfg_we,
	input  logic [wls_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wls_pkg::CFG_W-1:0]       cfg_data
);

	localparam int IDX_W      = $clog2(NUM_ENTRIES);
	localparam int NUM_GROUPS = (NUM_ENTRIES + wls_pkg::GROUP - 1) / wls_pkg::GROUP;
	localparam int PAD        = NUM_GROUPS * wls_pkg::GROUP;

	// ------------------------------------------------------------------
	// Configuration registers. The user must write only while the block is idle
	// (not enforced here), so the weights stay steady while a word is in flight.
	// ------------------------------------------------------------------
	logic [wls_pkg::CFG_W-1:0]  act_lo_q;
	logic [wls_pkg::HI_W-1:0]   act_hi_q;
	logic [wls_pkg::CFG_W-1:0]  mtg_lo_q;
	logic [wls_pkg::HI_W-1:0]   mtg_hi_q;
	logic [wls_pkg::MASK_W-1:0] mask_q;
	logic                       profile_q;
	logic                       text_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_lo_q  <= '0;
			act_hi_q  <= '0;
			mtg_lo_q  <= '0;
			mtg_hi_q  <= '0;
			mask_q    <= '1;
			profile_q <= 1'b0;
			text_q    <= 1'b0;
		end else if (cfg_we) begin
			case (wls_pkg::cfg_reg_t'(cfg_index))
				wls_pkg::REG_ACTIVE_LO:  act_lo_q  <= cfg_data;
				wls_pkg::REG_ACTIVE_HI:  act_hi_q  <= cfg_data[wls_pkg::HI_W-1:0];
				wls_pkg::REG_MEETING_LO: mtg_lo_q  <= cfg_data;
				wls_pkg::REG_MEETING_HI: mtg_hi_q  <= cfg_data[wls_pkg::HI_W-1:0];
				wls_pkg::REG_ENABLE:     mask_q    <= cfg_data[wls_pkg::MASK_W-1:0];
				wls_pkg::REG_PROFILE:    profile_q <= cfg_data[0];
				wls_pkg::REG_TEXT:       text_q    <= cfg_data[0];
				default: begin
					// Writes past the register list are dropped.
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Effective weight of each entry. The profile picks the weight set,
	// the mask gates each entry, and the text entry drops to zero when
	// no text is present. Entries past the twelve stored ones, and the
	// padding up to a whole group, weigh nothing.
	// ------------------------------------------------------------------
	logic [wls_pkg::CFG_W-1:0]    lo_sel;
	logic [wls_pkg::HI_W-1:0]     hi_sel;
	logic [wls_pkg::WEIGHT_W-1:0] w [PAD];

	assign lo_sel = profile_q ? mtg_lo_q : act_lo_q;
	assign hi_sel = profile_q ? mtg_hi_q : act_hi_q;

	for (genvar i = 0; i < PAD; i++) begin : g_weight
		if (i < wls_pkg::HW_ENTRIES && i < NUM_ENTRIES) begin : g_real
			localparam bit IS_TEXT = (i == TEXT_ENTRY);
			logic [wls_pkg::WEIGHT_W-1:0] raw;
			if (i < wls_pkg::LO_ENTRIES) begin : g_lo
				assign raw = lo_sel[i*wls_pkg::WEIGHT_W +: wls_pkg::WEIGHT_W];
			end else begin : g_hi
				assign raw = hi_sel[(i-wls_pkg::LO_ENTRIES)*wls_pkg::WEIGHT_W +:
					wls_pkg::WEIGHT_W];
			end
			assign w[i] = (mask_q[i] && !(IS_TEXT && !text_q)) ? raw : '0;
		end else begin : g_zero
			assign w[i] = '0;
		end
	end

	// ------------------------------------------------------------------
	// Pipeline advance. The whole chain moves together while the skid
	// register is empty; the output register and the skid register let a
	// finished word wait without holding up input for one more word.
	// ------------------------------------------------------------------
	logic en;
	logic skid_valid_q;

	assign en            = !skid_valid_q;
	assign pick_in.ready = en;

	// ------------------------------------------------------------------
	// Stage 1: sums of groups of four weights, with the draw beside them.
	// Stage 2: total weight from the group sums.
	// ------------------------------------------------------------------
	logic [wls_pkg::GRP_W-1:0]   grp_sum [NUM_GROUPS];
	logic [wls_pkg::GRP_W-1:0]   grp_s1 [NUM_GROUPS];
	logic [wls_pkg::RAND_W-1:0]  rand_s1;
	logic                        valid_s1;
	logic [wls_pkg::TOTAL_W-1:0] total_sum;
	logic [wls_pkg::TOTAL_W-1:0] total_s2;
	logic [wls_pkg::RAND_W-1:0]  rand_s2;
	logic                        valid_s2;

	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
		always_comb begin
			grp_sum[g] = '0;
			for (int k = 0; k < wls_pkg::GROUP; k++) begin
				grp_sum[g] = grp_sum[g] + wls_pkg::GRP_W'(w[g*wls_pkg::GROUP + k]);
			end
		end
	end

	always_comb begin
		total_sum = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			total_sum = total_sum + wls_pkg::TOTAL_W'(grp_s1[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pick_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_s1   <= grp_sum;
			rand_s1  <= pick_in.random_value;
			total_s2 <= total_sum;
			rand_s2  <= rand_s1;
		end
	end

	// ------------------------------------------------------------------
	// Modulo chain: one restoring cell per draw bit, MSB first, leaves
	// the roll = draw mod total. A zero total gives a meaningless roll,
	// which the output stage replaces with the fallback pick.
	// ------------------------------------------------------------------
	wls_pkg::mod_data_t mod_d [wls_pkg::RAND_W+1];
	logic               mod_v [wls_pkg::RAND_W+1];

	assign mod_v[0]          = valid_s2;
	assign mod_d[0].total    = total_s2;
	assign mod_d[0].rem      = '0;
	assign mod_d[0].dividend = rand_s2;

	for (genvar b = 0; b < wls_pkg::RAND_W; b++) begin : g_mod
		wls_mod_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (mod_v[b]),
			.d_i     (mod_d[b]),
			.valid_o (mod_v[b+1]),
			.d_o     (mod_d[b+1])
		);
	end

	// ------------------------------------------------------------------
	// Walk chain: one cell per entry in index order. The first entry
	// whose weight exceeds what is left of the roll claims the pick.
	// ------------------------------------------------------------------
	wls_pkg::walk_data_t walk_d [NUM_ENTRIES+1];
	logic                walk_v [NUM_ENTRIES+1];
	logic [IDX_W-1:0]    walk_sel [NUM_ENTRIES+1];

	assign walk_v[0]       = mod_v[wls_pkg::RAND_W];
	assign walk_d[0].total = mod_d[wls_pkg::RAND_W].total;
	assign walk_d[0].roll  = mod_d[wls_pkg::RAND_W].rem;
	assign walk_d[0].found = 1'b0;
	assign walk_sel[0]     = '0;

	for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_walk
		wls_walk_cell #(
			.IDX_W (IDX_W),
			.INDEX (e)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.weight  (w[e]),
			.valid_i (walk_v[e]),
			.d_i     (walk_d[e]),
			.sel_i   (walk_sel[e]),
			.valid_o (walk_v[e+1]),
			.d_o     (walk_d[e+1]),
			.sel_o   (walk_sel[e+1])
		);
	end

	// ------------------------------------------------------------------
	// Result forming: a zero total picks the fallback entry and flags it.
	// ------------------------------------------------------------------
	logic                        res_zero;
	logic [wls_pkg::SEL_W-1:0]   res_sel;
	logic                        deliver;

	assign res_zero = (walk_d[NUM_ENTRIES].total == '0);
	assign res_sel  = res_zero ? wls_pkg::SEL_W'(FALLBACK_ENTRY)
	                           : wls_pkg::SEL_W'(walk_sel[NUM_ENTRIES]);
	assign deliver  = en && walk_v[NUM_ENTRIES];

	// ------------------------------------------------------------------
	// Output register with a skid register behind it. When the output is
	// free or being taken, it loads from the skid register first, else
	// from the chain; when it is held, a word leaving the chain parks in
	// the skid register, which stops the chain until it drains.
	// ------------------------------------------------------------------
	logic                        out_valid_q;
	logic [wls_pkg::SEL_W-1:0]   out_sel_q;
	logic                        out_fb_q;
	logic [wls_pkg::TOTAL_W-1:0] out_total_q;
	logic [wls_pkg::SEL_W-1:0]   skid_sel_q;
	logic                        skid_fb_q;
	logic [wls_pkg::TOTAL_W-1:0] skid_total_q;
	logic                        out_free;

	assign out_free = !out_valid_q || pick_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= deliver;
			end
		end else if (deliver) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_sel_q   <= skid_sel_q;
				out_fb_q    <= skid_fb_q;
				out_total_q <= skid_total_q;
			end else if (deliver) begin
				out_sel_q   <= res_sel;
				out_fb_q    <= res_zero;
				out_total_q <= walk_d[NUM_ENTRIES].total;
			end
		end else if (deliver) begin
			skid_sel_q   <= res_sel;
			skid_fb_q    <= res_zero;
			skid_total_q <= walk_d[NUM_ENTRIES].total;
		end
	end

	assign pick_out.valid          = out_valid_q;
	assign pick_out.selected_entry = out_sel_q;
	assign pick_out.fallback_used  = out_fb_q;
	assign pick_out.total_weight   = out_total_q;

endmodule

@@ sim/tb_weighted_lottery_selector_unit.sv @@
// ----------------------------------------------------------------------------
// Weighted lottery selector testbench
// Drives random draws into the selector under many weight, mask, profile and
// text settings. Each accepted draw is run through a local roulette-wheel
// model, and every pick word that comes out is checked against it in order.
// ----------------------------------------------------------------------------
module tb_weighted_lottery_selector_unit;

	import wls_pkg::*;

	// A register index that the block does not decode; writes to it must
	// leave every register unchanged.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// Pipeline depth of the block, plus some margin for the tail.
	localparam int PIPE_LATENCY = RAND_W + NUM_ENTRIES_DEF + 3;
	localparam int TAIL_CYCLES  = PIPE_LATENCY + 10;

	// Cycles with no word moving on either channel before the run is called
	// hung. The longest legitimate quiet stretch is the long receiver hold
	// plus the pipeline depth, so this is several times the worst case.
	localparam int WATCHDOG_LIMIT = 2000;

	localparam int LONG_HOLD_CYCLES = 160;
	localparam int BATCHES_PER_PHASE = 5;
	localparam int DRAWS_PER_BATCH   = 60;
	localparam int MAX_REPORTS       = 10;

	typedef struct {
		logic [SEL_W-1:0]   entry;
		logic               fallback;
		logic [TOTAL_W-1:0] total;
	} pick_t;

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	wls_in_if  pick_in ();
	wls_out_if pick_out ();

	weighted_lottery_selector_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pick_in   (pick_in),
		.pick_out  (pick_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Local copy of the selector's registers, updated as each write is issued.
	logic [63:0]       active_lo_reg;
	logic [HI_W-1:0]   active_hi_reg;
	logic [63:0]       meeting_lo_reg;
	logic [HI_W-1:0]   meeting_hi_reg;
	logic [MASK_W-1:0] enable_reg;
	logic              meeting_sel;
	logic              text_reg;

	logic [RAND_W-1:0] pending_draws[$];
	pick_t             expected_picks[$];

	// Idle percentages for the two sides, changed between phases.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	int unsigned draws_accepted;
	int unsigned picks_checked;
	int unsigned fallbacks_seen;
	int unsigned settings_applied;
	int unsigned error_count;
	int unsigned hold_left;
	int unsigned quiet_cycles;

	// Effective weight of one entry under the current settings: zero when the
	// entry is masked off, and zero for the text entry while no text is there.
	function automatic int unsigned entry_weight_of(int unsigned idx);
		logic [63:0]     lo;
		logic [HI_W-1:0] hi;
		int unsigned     w;
		lo = meeting_sel ? meeting_lo_reg : active_lo_reg;
		hi = meeting_sel ? meeting_hi_reg : active_hi_reg;
		if (idx >= HW_ENTRIES || !enable_reg[idx])
			return 0;
		if (idx < LO_ENTRIES)
			w = 32'(lo[idx*WEIGHT_W +: WEIGHT_W]);
		else
			w = 32'(hi[(idx-LO_ENTRIES)*WEIGHT_W +: WEIGHT_W]);
		if (idx == TEXT_ENTRY_DEF && !text_reg)
			w = 0;
		return w;
	endfunction

	// Roulette-wheel pick: reduce the draw modulo the total, then walk the
	// entries in order until the remaining roll falls inside one of them.
	function automatic pick_t predict_pick(logic [RAND_W-1:0] draw);
		int unsigned total;
		int unsigned roll;
		int unsigned w;
		pick_t       p;
		total = 0;
		for (int i = 0; i < NUM_ENTRIES_DEF; i++)
			total += entry_weight_of(i);
		p.entry    = '0;
		p.fallback = 1'b0;
		p.total    = TOTAL_W'(total);
		if (total == 0) begin
			p.entry    = SEL_W'(FALLBACK_ENTRY_DEF);
			p.fallback = 1'b1;
			return p;
		end
		roll = 32'(draw) % total;
		for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
			w = entry_weight_of(i);
			if (roll < w) begin
				p.entry = SEL_W'(i);
				break;
			end
			roll -= w;
		end
		return p;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Draw driver. A new word is offered only when the previous one has been
	// taken or none is up; the expected pick is computed at acceptance, with
	// the settings that are in force then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_in.valid        <= 1'b0;
			pick_in.random_value <= '0;
		end else begin
			if (pick_in.valid && pick_in.ready) begin
				expected_picks.push_back(predict_pick(pick_in.random_value));
				draws_accepted++;
			end
			if (!pick_in.valid || pick_in.ready) begin
				if (pending_draws.size() != 0 &&
						$urandom_range(99, 0) >= send_idle_pct) begin
					pick_in.valid        <= 1'b1;
					pick_in.random_value <= pending_draws.pop_front();
				end else begin
					pick_in.valid <= 1'b0;
				end
			end
		end
	end

	// Pick monitor and receiver. Twice in the run the receiver holds ready
	// low for a long stretch so that the pipeline fills and the block has to
	// push back on the draw channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_out.ready <= 1'b0;
		end else begin
			if (pick_out.valid && pick_out.ready) begin
				if (expected_picks.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected pick word: entry %0d fallback %0b total %0d",
							pick_out.selected_entry, pick_out.fallback_used,
							pick_out.total_weight);
				end else begin
					pick_t exp_pick;
					exp_pick = expected_picks.pop_front();
					if (pick_out.selected_entry !== exp_pick.entry ||
							pick_out.fallback_used !== exp_pick.fallback ||
							pick_out.total_weight !== exp_pick.total) begin
						error_count++;
						if (error_count <= MAX_REPORTS) begin
							$write("pick mismatch #%0d: expected entry %0d fallback %0b total %0d, ",
								picks_checked, exp_pick.entry, exp_pick.fallback,
								exp_pick.total);
							$display("got entry %0d fallback %0b total %0d",
								pick_out.selected_entry, pick_out.fallback_used,
								pick_out.total_weight);
						end
					end
					if (exp_pick.fallback)
						fallbacks_seen++;
				end
				picks_checked++;
				if (picks_checked == 250 || picks_checked == 750)
					hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pick_out.ready <= 1'b0;
			end else begin
				pick_out.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: ends the run if no word moves on either channel for too long.
	always @(posedge clk) begin
		if ((pick_in.valid && pick_in.ready) || (pick_out.valid && pick_out.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d picks outstanding",
				quiet_cycles, expected_picks.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Register write: one cycle with the write enable high. The local copy is
	// updated at the same edge; writes only happen with nothing in flight.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_ACTIVE_LO:  active_lo_reg  = data;
			REG_ACTIVE_HI:  active_hi_reg  = data[HI_W-1:0];
			REG_MEETING_LO: meeting_lo_reg = data;
			REG_MEETING_HI: meeting_hi_reg = data[HI_W-1:0];
			REG_ENABLE:     enable_reg     = data[MASK_W-1:0];
			REG_PROFILE:    meeting_sel    = data[0];
			REG_TEXT:       text_reg       = data[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every queued draw has gone in and every pick has come out.
	// Each draw yields exactly one pick, so the pipeline is empty then.
	task automatic wait_for_drain();
		@(negedge clk);
		while (pending_draws.size() != 0 || pick_in.valid || expected_picks.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] random_weight_byte(int unsigned style);
		case (style)
			0: return 8'($urandom_range(255, 0));
			1: return ($urandom_range(3, 0) == 0) ? 8'($urandom_range(255, 0)) : 8'd0;
			2: return ($urandom_range(1, 0) == 0) ? 8'hFF : 8'($urandom_range(3, 0));
			default: begin
				case ($urandom_range(3, 0))
					0: return 8'd0;
					1: return 8'hFF;
					2: return 8'd1;
					default: return 8'($urandom_range(255, 0));
				endcase
			end
		endcase
	endfunction

	function automatic logic [63:0] random_weight_word(int unsigned style);
		logic [63:0] word;
		for (int b = 0; b < 8; b++)
			word[b*8 +: 8] = random_weight_byte(style);
		return word;
	endfunction

	// Draws mostly span the full 16-bit range; some sit at the ends or below
	// the largest possible total so that small rolls are common too.
	function automatic logic [RAND_W-1:0] random_draw();
		case ($urandom_range(7, 0))
			0: return '0;
			1: return '1;
			2: return RAND_W'($urandom_range(3060, 0));
			default: return RAND_W'($urandom_range(65535, 0));
		endcase
	endfunction

	// A full random setting: both profiles' weights, the mask, the profile
	// and the text flag. Upper data bits are junk so that the register width
	// truncation is exercised on every write to a narrower register.
	task automatic apply_random_setting();
		logic [CFG_W-1:0] value;
		int unsigned      style;
		style = $urandom_range(3, 0);
		write_reg(REG_ACTIVE_LO, random_weight_word(style));
		write_reg(REG_ACTIVE_HI, random_weight_word(style));
		write_reg(REG_MEETING_LO, random_weight_word(style));
		write_reg(REG_MEETING_HI, random_weight_word(style));
		value = {$urandom(), $urandom()};
		case ($urandom_range(5, 0))
			0: value[MASK_W-1:0] = '1;
			1: value[MASK_W-1:0] = '0;
			2: value[MASK_W-1:0] = 12'd1 << $urandom_range(HW_ENTRIES-1, 0);
			default: ;
		endcase
		write_reg(REG_ENABLE, value);
		write_reg(REG_PROFILE, {$urandom(), $urandom()});
		write_reg(REG_TEXT, {$urandom(), $urandom()});
		if ($urandom_range(3, 0) == 0)
			write_reg(REG_UNUSED, {$urandom(), $urandom()});
		settings_applied++;
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		pick_in.valid        = 1'b0;
		pick_in.random_value = '0;
		pick_out.ready       = 1'b0;
		active_lo_reg        = '0;
		active_hi_reg        = '0;
		meeting_lo_reg       = '0;
		meeting_hi_reg       = '0;
		enable_reg           = '1;
		meeting_sel          = 1'b0;
		text_reg             = 1'b0;
		send_idle_pct        = 16;
		recv_idle_pct        = 75;
		draws_accepted       = 0;
		picks_checked        = 0;
		fallbacks_seen       = 0;
		settings_applied     = 0;
		error_count          = 0;
		hold_left            = 0;
		quiet_cycles         = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Straight out of reset every weight is zero, so both draws must take
		// the fallback entry whatever their value.
		pending_draws.push_back(16'h0000);
		pending_draws.push_back(16'hFFFF);
		wait_for_drain();

		// Every active weight at its maximum with text present: the total is
		// at its ceiling, the draw wraps at the total, and the roll crosses
		// the boundary between the first two entries.
		write_reg(REG_ACTIVE_LO, '1);
		write_reg(REG_ACTIVE_HI, '1);
		write_reg(REG_TEXT, 64'd1);
		pending_draws.push_back(16'h0000);
		pending_draws.push_back(16'hFFFF);
		pending_draws.push_back(16'd3059);
		pending_draws.push_back(16'd3060);
		pending_draws.push_back(16'd254);
		pending_draws.push_back(16'd255);
		wait_for_drain();

		// Without text the text entry drops out and the walk skips over it:
		// the first roll lands on the entry below it, the second just above.
		write_reg(REG_TEXT, 64'd0);
		pending_draws.push_back(16'd2039);
		pending_draws.push_back(16'd2040);
		wait_for_drain();

		// Meeting profile with a single weight on the last entry.
		write_reg(REG_MEETING_LO, '0);
		write_reg(REG_MEETING_HI, 64'h0000_0000_0100_0000);
		write_reg(REG_PROFILE, 64'd1);
		pending_draws.push_back(16'h0000);
		pending_draws.push_back(16'hFFFF);
		wait_for_drain();

		// Only the text entry weighted: a zero total while no text is there,
		// and that entry alone once text appears.
		write_reg(REG_MEETING_HI, 64'h0000_0000_0000_0080);
		pending_draws.push_back(16'h1234);
		wait_for_drain();
		write_reg(REG_TEXT, 64'd1);
		pending_draws.push_back(16'h4321);
		wait_for_drain();

		// Back to the full active weights with every entry masked off, then
		// with one entry left on.
		write_reg(REG_PROFILE, 64'd0);
		write_reg(REG_ENABLE, 64'd0);
		pending_draws.push_back(16'hBEEF);
		wait_for_drain();
		write_reg(REG_ENABLE, 64'h0000_0000_0000_0020);
		pending_draws.push_back(16'hCAFE);
		wait_for_drain();

		// A write to an undecoded index must not disturb any register.
		write_reg(REG_UNUSED, '1);
		pending_draws.push_back(16'h5A5A);
		wait_for_drain();
		settings_applied += 8;

		// Random part: three idling patterns, each with several settings.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					recv_idle_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int batch = 0; batch < BATCHES_PER_PHASE; batch++) begin
				wait_for_drain();
				apply_random_setting();
				for (int n = 0; n < DRAWS_PER_BATCH; n++)
					pending_draws.push_back(random_draw());
			end
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d draws and %0d picks under %0d register settings,",
			draws_accepted, picks_checked, settings_applied);
		$display("%0d picks took the fallback entry; %0d errors, %0d picks left over",
			fallbacks_seen, error_count, expected_picks.size());
		if (error_count == 0 && expected_picks.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/wls_pkg.sv
rtl/wls_if.sv
rtl/wls_mod_cell.sv
rtl/wls_walk_cell.sv
rtl/weighted_lottery_selector_unit.sv
sim/tb_weighted_lottery_selector_unit.sv
